// File: sv/integer_literal_parser_assert.svh
// Assertion helpers for the checker of the literal parser.
`ifndef INTEGER_LITERAL_PARSER_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_ASSERT_SVH

// Clocked assertion, switched off while reset is active.
`define ILP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same, on the standard clock and reset port names.
`define ILP_ASSERT_STD(lbl, prop, msg) \
  `ILP_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: sv/ilp_pkg.sv
package ilp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned ErrW   = 3;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned CountW = 7;
  localparam int unsigned DigitW = 4;

  // Radix mode codes
  localparam logic [ModeW-1:0] ModeStart = 3'd0;
  localparam logic [ModeW-1:0] ModeDec   = 3'd1;
  localparam logic [ModeW-1:0] ModeZero  = 3'd2;
  localparam logic [ModeW-1:0] ModeHex   = 3'd3;
  localparam logic [ModeW-1:0] ModeBin   = 3'd4;
  localparam logic [ModeW-1:0] ModeOct   = 3'd5;

  // Error codes
  localparam logic [ErrW-1:0] ErrOk  = 3'd0;
  localparam logic [ErrW-1:0] ErrDec = 3'd1;
  localparam logic [ErrW-1:0] ErrHex = 3'd2;
  localparam logic [ErrW-1:0] ErrBin = 3'd3;
  localparam logic [ErrW-1:0] ErrOct = 3'd4;

  // Character codes
  localparam logic [CharW-1:0] CharZero   = 8'h30;
  localparam logic [CharW-1:0] CharLowX   = 8'h78;
  localparam logic [CharW-1:0] CharUpX    = 8'h58;
  localparam logic [CharW-1:0] CharLowB   = 8'h62;
  localparam logic [CharW-1:0] CharUpB    = 8'h42;
  localparam logic [CharW-1:0] CharUpA    = 8'h41;
  localparam logic [CharW-1:0] CharUpF    = 8'h46;
  localparam logic [CharW-1:0] CharLowA   = 8'h61;
  localparam logic [CharW-1:0] CharLowF   = 8'h66;
  localparam logic [CharW-1:0] UpLetterBias  = 8'h37;
  localparam logic [CharW-1:0] LowLetterBias = 8'h57;

  // Digit count limits
  localparam logic [CountW-1:0] CountMax = 7'd127;
  localparam logic [CountW-1:0] HexLimit = 7'd16;
  localparam logic [CountW-1:0] BinLimit = 7'd64;
  localparam logic [CountW-1:0] OctLimit = 7'd22;

  // Largest accumulator that can take one more decimal digit
  localparam logic [ValueW-1:0] DecLimitQ = 64'd1844674407370955161;
  localparam logic [DigitW-1:0] DecLastDigitMax = 4'd5;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [ValueW-1:0] acc;
    logic [CountW-1:0] count;
    logic              too_big;
  } ilp_state_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [ErrW-1:0]   err;
  } ilp_result_t;

  localparam ilp_state_t StateReset = '{
    mode: ModeStart, acc: '0, count: '0, too_big: 1'b0
  };

  function automatic logic [DigitW-1:0] digit_of(input logic [CharW-1:0] c);
    logic [CharW-1:0] diff;
    diff = c;
    if (c >= CharUpA && c <= CharUpF) begin
      diff = c - UpLetterBias;
    end else if (c >= CharLowA && c <= CharLowF) begin
      diff = c - LowLetterBias;
    end
    return diff[DigitW-1:0];
  endfunction

  function automatic logic [CountW-1:0] count_inc(input logic [CountW-1:0] c);
    return (c == CountMax) ? c : c + 1'b1;
  endfunction

endpackage

// File: sv/ilp_char_if.sv
interface ilp_char_if;
  logic                         valid;
  logic                         ready;
  logic [ilp_pkg::CharW-1:0]    char_code;
  logic                         last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: sv/ilp_result_if.sv
interface ilp_result_if;
  logic                         valid;
  logic                         ready;
  logic [ilp_pkg::ValueW-1:0]   parsed_value;
  logic [ilp_pkg::ErrW-1:0]     error_code;

  modport source (output valid, output parsed_value, output error_code, input ready);
  modport sink   (input valid, input parsed_value, input error_code, output ready);
endinterface

// File: sv/integer_literal_parser.sv
// Integer literal parser.
// char_i takes the characters of one C-style integer literal, most
// significant first, one request per character, with last_char set on the
// final one. Decimal, 0x/0X hex, 0b/0B binary and leading-zero octal are
// recognized. result_o gives one request per literal: the 64-bit value and
// an error code (nonzero with a zero value when the literal overflows).
// A last character goes from the input register to the result register,
// which drives result_o. Throughput: one character per cycle unless a last
// character waits on a stalled result; each character costs a single
// shift-add of the accumulator between the input and result registers.
// Reset clears the input register, the literal state and the result valid,
// so the next character starts a new literal.
// When the sink stalls, the result waits in the output register; characters
// that are not last keep flowing, and a further last character is held in
// the input register, which drops char_i.ready until the result is taken.
module integer_literal_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  ilp_char_if.sink      char_i,
  ilp_result_if.source  result_o
);

  logic                        s1_valid_q;
  logic                        s1_valid_d;
  logic [ilp_pkg::CharW-1:0]   s1_char_q;
  logic                        s1_last_q;
  logic                        s1_go;
  logic                        accept;
  logic                        out_free;
  ilp_pkg::ilp_state_t         state_q;
  ilp_pkg::ilp_state_t         state_d;
  ilp_pkg::ilp_result_t        step_result;

  // Advance the input stage unless a finished literal has nowhere to go
  assign s1_go        = s1_valid_q && (!s1_last_q || out_free);
  assign char_i.ready = !s1_valid_q || s1_go;
  assign accept       = char_i.valid && char_i.ready;
  assign s1_valid_d   = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_char_q <= char_i.char_code;
      s1_last_q <= char_i.last_char;
    end
  end

  ilp_step u_step (
    .state_i     (state_q),
    .char_code_i (s1_char_q),
    .last_char_i (s1_last_q),
    .state_o     (state_d),
    .result_o    (step_result)
  );

  // Update the literal state once per processed character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ilp_pkg::StateReset;
    end else if (s1_go) begin
      state_q <= state_d;
    end
  end

  ilp_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (s1_go && s1_last_q),
    .result_i (step_result),
    .free_o   (out_free),
    .result_o (result_o)
  );

endmodule

// File: sv/ilp_step.sv
module ilp_step (
  input  ilp_pkg::ilp_state_t        state_i,
  input  logic [ilp_pkg::CharW-1:0]  char_code_i,
  input  logic                       last_char_i,
  output ilp_pkg::ilp_state_t        state_o,
  output ilp_pkg::ilp_result_t       result_o
);

  logic [ilp_pkg::DigitW-1:0] digit;
  ilp_pkg::ilp_state_t        base;
  ilp_pkg::ilp_state_t        nxt;
  logic                       do_dec;
  logic                       do_oct;
  logic [ilp_pkg::CountW-1:0] cnt;
  logic [ilp_pkg::ErrW-1:0]   kind;

  assign digit = ilp_pkg::digit_of(char_code_i);

  // Fold one character into the literal state
  always_comb begin
    base   = state_i;
    nxt    = state_i;
    do_dec = 1'b0;
    do_oct = 1'b0;
    cnt    = ilp_pkg::count_inc(state_i.count);
    unique case (state_i.mode)
      ilp_pkg::ModeDec: begin
        do_dec = 1'b1;
      end
      ilp_pkg::ModeZero: begin
        if (char_code_i == ilp_pkg::CharLowX || char_code_i == ilp_pkg::CharUpX) begin
          nxt.mode = ilp_pkg::ModeHex;
        end else if (char_code_i == ilp_pkg::CharLowB ||
                     char_code_i == ilp_pkg::CharUpB) begin
          nxt.mode = ilp_pkg::ModeBin;
        end else begin
          do_oct = 1'b1;
        end
      end
      ilp_pkg::ModeHex: begin
        nxt.count   = cnt;
        nxt.too_big = state_i.too_big | (cnt > ilp_pkg::HexLimit);
        nxt.acc     = {state_i.acc[ilp_pkg::ValueW-5:0], digit};
      end
      ilp_pkg::ModeBin: begin
        nxt.count   = cnt;
        nxt.too_big = state_i.too_big | (cnt > ilp_pkg::BinLimit);
        nxt.acc     = {state_i.acc[ilp_pkg::ValueW-2:0], digit[0]};
      end
      ilp_pkg::ModeOct: begin
        do_oct = 1'b1;
      end
      default: begin
        // start of a literal: clear, then take a zero or a decimal digit
        base = ilp_pkg::StateReset;
        nxt  = ilp_pkg::StateReset;
        if (char_code_i == ilp_pkg::CharZero) begin
          nxt.mode = ilp_pkg::ModeZero;
        end else begin
          do_dec = 1'b1;
        end
      end
    endcase

    if (do_dec) begin
      nxt.mode    = ilp_pkg::ModeDec;
      nxt.count   = ilp_pkg::count_inc(base.count);
      nxt.acc     = base.acc;
      nxt.too_big = base.too_big;
      if (!base.too_big) begin
        if (base.acc > ilp_pkg::DecLimitQ ||
            (base.acc == ilp_pkg::DecLimitQ && digit > ilp_pkg::DecLastDigitMax)) begin
          nxt.too_big = 1'b1;
        end else begin
          nxt.acc = (base.acc << 3) + (base.acc << 1) +
                    {{(ilp_pkg::ValueW-ilp_pkg::DigitW){1'b0}}, digit};
        end
      end
    end

    if (do_oct) begin
      nxt.mode    = ilp_pkg::ModeOct;
      nxt.count   = ilp_pkg::count_inc(base.count);
      nxt.too_big = base.too_big | (ilp_pkg::count_inc(base.count) > ilp_pkg::OctLimit) |
                    (|base.acc[ilp_pkg::ValueW-1:ilp_pkg::ValueW-3]);
      nxt.acc     = {base.acc[ilp_pkg::ValueW-4:0], digit[2:0]};
    end
  end

  // Map the final radix to its overflow code
  always_comb begin
    unique case (nxt.mode)
      ilp_pkg::ModeDec: kind = ilp_pkg::ErrDec;
      ilp_pkg::ModeHex: kind = ilp_pkg::ErrHex;
      ilp_pkg::ModeBin: kind = ilp_pkg::ErrBin;
      ilp_pkg::ModeOct: kind = ilp_pkg::ErrOct;
      default:          kind = ilp_pkg::ErrOk;
    endcase
  end

  // Build the result and return to the start on the last character
  always_comb begin
    if (nxt.too_big && kind != ilp_pkg::ErrOk) begin
      result_o.value = '0;
      result_o.err   = kind;
    end else begin
      result_o.value = nxt.acc;
      result_o.err   = ilp_pkg::ErrOk;
    end
    state_o = last_char_i ? ilp_pkg::StateReset : nxt;
  end

endmodule

// File: sv/ilp_out_reg.sv
module ilp_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  ilp_pkg::ilp_result_t  result_i,
  output logic                  free_o,
  ilp_result_if.source          result_o
);

  logic                 valid_q;
  logic                 valid_d;
  ilp_pkg::ilp_result_t data_q;

  assign free_o  = !valid_q || result_o.ready;
  assign valid_d = load_i ? 1'b1 : (result_o.ready ? 1'b0 : valid_q);

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign result_o.valid        = valid_q;
  assign result_o.parsed_value = data_q.value;
  assign result_o.error_code   = data_q.err;

endmodule

// File: sv/ilp_checker.sv
`include "integer_literal_parser_assert.svh"

module ilp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ilp_pkg::ValueW-1:0]  parsed_value_i,
  input logic [ilp_pkg::ErrW-1:0]    error_code_i
);

  // Hold a stalled result request
  `ILP_ASSERT_STD(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(parsed_value_i) && $stable(error_code_i), "result changed while stalled")

  // Overflowed literals carry a zero value
  `ILP_ASSERT_STD(a_err_zero, out_valid_i && error_code_i != ilp_pkg::ErrOk |-> parsed_value_i == '0, "overflow with nonzero value")

  // Drop input ready only behind a stalled result
  `ILP_ASSERT_STD(a_stall_cause, !in_ready_i |-> out_valid_i && !out_ready_i, "input stalled without a waiting result")

  // Valid input is not blocked while the result side is free
  `ILP_ASSERT(a_no_idle_stall, clk_i, rst_ni, in_valid_i && !out_valid_i |-> in_ready_i, "input stalled with free output")

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (char_i.valid),
  .in_ready_i     (char_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .parsed_value_i (result_o.parsed_value),
  .error_code_i   (result_o.error_code)
);

// File: tb/integer_literal_parser_test.sv
module integer_literal_parser_test;
  import ilp_pkg::*;

  localparam int unsigned ItemTarget = 1650;
  localparam int unsigned CalmAfter  = ItemTarget * 85 / 100;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;

  typedef logic [CharW-1:0] char_q_t[$];

  // Literal parser model plus the queue of results still owed by the block
  class literal_scoreboard;
    logic [ModeW-1:0]  mode;
    logic [ValueW-1:0] acc;
    logic [CountW-1:0] count;
    bit                too_big;
    ilp_result_t       pending_literals[$];
    int unsigned       failures;
    int unsigned       results_seen;

    function new();
      clear_literal();
      failures     = 0;
      results_seen = 0;
    endfunction

    function void clear_literal();
      mode    = ModeStart;
      acc     = '0;
      count   = '0;
      too_big = 1'b0;
    endfunction

    // Letters a-f and A-F map to 10..15; anything else is taken as c - '0', low nibble
    function logic [DigitW-1:0] char_digit(logic [CharW-1:0] c);
      logic [CharW-1:0] offs;
      if (c >= CharUpA && c <= CharUpF) begin
        offs = c - CharUpA + 8'd10;
      end else if (c >= CharLowA && c <= CharLowF) begin
        offs = c - CharLowA + 8'd10;
      end else begin
        offs = c - CharZero;
      end
      return offs[DigitW-1:0];
    endfunction

    // Advance the digit count, saturating, and flag a literal that is too long
    function void bump_count(logic [CountW-1:0] limit);
      if (count != CountMax) count++;
      if (count > limit) too_big = 1'b1;
    endfunction

    // Fold a decimal digit unless the next multiply-add would pass 2^64-1
    function void fold_decimal(logic [DigitW-1:0] d);
      mode = ModeDec;
      if (!too_big) begin
        if (acc > DecLimitQ || (acc == DecLimitQ && d > DecLastDigitMax)) begin
          too_big = 1'b1;
        end else begin
          acc = acc * 64'd10 + ValueW'(d);
        end
      end
      if (count != CountMax) count++;
    endfunction

    // Fold an octal digit; any bit shifted out of the top, or a literal over the octal limit, is an overflow
    function void fold_octal(logic [DigitW-1:0] d);
      bump_count(OctLimit);
      if (acc[ValueW-1 -: 3] != 3'd0) too_big = 1'b1;
      acc = {acc[ValueW-4:0], d[2:0]};
    endfunction

    function void note_char(logic [CharW-1:0] c, bit last_flag);
      logic [DigitW-1:0] d;
      logic [ErrW-1:0]   kind;
      ilp_result_t       res;
      d = char_digit(c);
      case (mode)
        ModeDec: fold_decimal(d);
        ModeZero: begin
          if (c == CharLowX || c == CharUpX) begin
            mode = ModeHex;
          end else if (c == CharLowB || c == CharUpB) begin
            mode = ModeBin;
          end else begin
            mode = ModeOct;
            fold_octal(d);
          end
        end
        ModeHex: begin
          bump_count(HexLimit);
          acc = {acc[ValueW-5:0], d};
        end
        ModeBin: begin
          bump_count(BinLimit);
          acc = {acc[ValueW-2:0], d[0]};
        end
        ModeOct: fold_octal(d);
        default: begin
          clear_literal();
          if (c == CharZero) begin
            mode = ModeZero;
          end else begin
            fold_decimal(d);
          end
        end
      endcase
      if (!last_flag) return;

      // Close the literal: an overflow reports the radix and a zero value
      case (mode)
        ModeDec: kind = ErrDec;
        ModeHex: kind = ErrHex;
        ModeBin: kind = ErrBin;
        ModeOct: kind = ErrOct;
        default: kind = ErrOk;
      endcase
      if (too_big && kind != ErrOk) begin
        res.value = '0;
        res.err   = kind;
      end else begin
        res.value = acc;
        res.err   = ErrOk;
      end
      pending_literals.push_back(res);
      clear_literal();
    endfunction

    function void check_result(logic [ValueW-1:0] value, logic [ErrW-1:0] err);
      ilp_result_t want;
      results_seen++;
      if (pending_literals.size() == 0) begin
        failures++;
        if (failures <= MaxReports) begin
          $display("result %0d: value %h code %0d with no literal pending",
                   results_seen, value, err);
        end
        return;
      end
      want = pending_literals.pop_front();
      if (value !== want.value || err !== want.err) begin
        failures++;
        if (failures <= MaxReports) begin
          $display("result %0d: value %h code %0d, wanted value %h code %0d",
                   results_seen, value, err, want.value, want.err);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ilp_char_if   char_bus();
  ilp_result_if result_bus();

  integer_literal_parser i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_bus),
    .result_o (result_bus)
  );

  literal_scoreboard board;
  int unsigned       items_sent;
  int unsigned       cycle_count = 0;
  bit                calm = 1'b0;
  bit                quiet = 1'b0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Count cycles, switch quiet stretches on and off, and stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[7:0] == 8'd0) begin
      quiet <= ($urandom_range(0, 3) == 0);
    end
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Check every result request taken from the block
  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      board.check_result(result_bus.parsed_value, result_bus.error_code);
    end
  end

  // Stall the result side in random bursts
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && !calm && !quiet && $urandom_range(0, 11) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      result_bus.ready <= 1'b1;
    end
  end

  function automatic char_q_t chars_of(string s);
    char_q_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s.getc(i));
    return text;
  endfunction

  // Send one character request, with an optional idle burst before it
  task automatic send_char(logic [CharW-1:0] c, bit last_flag);
    if (!calm && !quiet && $urandom_range(0, 9) == 0) begin
      char_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    char_bus.last_char <= last_flag;
    do @(posedge clk_i); while (!char_bus.ready);
    board.note_char(c, last_flag);
    items_sent++;
    if (items_sent >= CalmAfter) calm = 1'b1;
  endtask

  task automatic send_text(char_q_t text);
    for (int i = 0; i < text.size(); i++) begin
      send_char(text[i], i == text.size() - 1);
    end
  endtask

  function automatic logic [CharW-1:0] octal_char(int unsigned lo, int unsigned hi);
    return CharZero + CharW'($urandom_range(lo, hi));
  endfunction

  // Build one literal: mostly well formed, some near the overflow edges,
  // the rest noise and broken prefixes
  function automatic char_q_t random_literal();
    char_q_t          text;
    logic [ValueW-1:0] value;
    string            hex_set;
    int unsigned      pick;
    int unsigned      n;
    hex_set = "0123456789abcdefABCDEF";
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      n = $urandom_range(0, 99);
      if (n < 70) begin
        value = {$urandom, $urandom} >> $urandom_range(0, 63);
        text = chars_of($sformatf("%0d", value));
      end else if (n < 85) begin
        text = chars_of("1844674407370955161");
        text.push_back(octal_char(0, 9));
      end else begin
        text.push_back(octal_char(1, 9));
        repeat ($urandom_range(0, 23)) text.push_back(octal_char(0, 9));
      end
    end else if (pick < 45) begin
      text.push_back(CharZero);
      text.push_back($urandom_range(0, 1) ? CharLowX : CharUpX);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 8);
      repeat (n) text.push_back(hex_set.getc($urandom_range(0, 21)));
    end else if (pick < 60) begin
      text.push_back(CharZero);
      text.push_back($urandom_range(0, 1) ? CharLowB : CharUpB);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(62, 67) : $urandom_range(0, 12);
      repeat (n) text.push_back(octal_char(0, 1));
    end else if (pick < 80) begin
      n = $urandom_range(0, 7);
      if (n == 0) begin
        text = chars_of("1777777777777777777777");
      end else if (n == 1) begin
        text = chars_of("2000000000000000000000");
      end else if (n == 2) begin
        text.push_back(octal_char(1, 3));
        repeat ($urandom_range(20, 22)) text.push_back(octal_char(0, 7));
      end else begin
        repeat ($urandom_range(1, 8)) text.push_back(octal_char(0, 7));
      end
      text.push_front(CharZero);
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 8)) text.push_back(CharW'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 3);
      if (n == 0) text = chars_of("0x");
      else if (n == 1) text = chars_of("0b");
      else if (n == 2) text = chars_of("0");
      else text = chars_of("7");
      repeat ($urandom_range(1, 6)) text.push_back(CharW'($urandom_range(0, 255)));
    end
    return text;
  endfunction

  initial begin
    board = new();
    items_sent = 0;
    rst_ni = 1'b0;
    char_bus.valid     = 1'b0;
    char_bus.char_code = '0;
    char_bus.last_char = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Lone zero, bare prefixes, letter digits and a letter in octal and in decimal
    send_text(chars_of("0"));
    send_text(chars_of("0x"));
    send_text(chars_of("0X"));
    send_text(chars_of("0b"));
    send_text(chars_of("0B"));
    send_text(chars_of("0XfF"));
    send_text(chars_of("0b1"));
    send_text(chars_of("9"));
    send_text(chars_of("07"));
    send_text(chars_of("0A"));
    send_text(chars_of("5f"));

    while (items_sent < ItemTarget) send_text(random_literal());
    char_bus.valid <= 1'b0;

    // Drain outstanding results, then allow the output register to settle
    while (board.pending_literals.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/ilp_pkg.sv
sv/ilp_char_if.sv
sv/ilp_result_if.sv
sv/ilp_step.sv
sv/ilp_out_reg.sv
sv/integer_literal_parser.sv
sv/ilp_checker.sv
tb/integer_literal_parser_test.sv
